[rtl/ldm_pkg.sv]
// Shared types and constants for the load dispersion monitor.
`default_nettype none
package ldm_pkg;
	localparam int unsigned RxBits = 4;
	localparam int unsigned MaskBits = 16;
	localparam int unsigned IdxBits = 32;
	localparam logic [0:0] CfgMaxIndex = 1'b0;
	localparam logic [0:0] CfgTargetMask = 1'b1;

	typedef struct packed {
		logic       count;
		logic [RxBits-1:0] rx_node;
		logic       in_range;
	} ldm_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DIV,
		ST_OUT
	} ldm_state_t;
endpackage
`default_nettype wire

[rtl/ldm_front.sv]
// Input stage: classifies requests and queues them for the back end.
`default_nettype none
module ldm_front #(
	parameter int unsigned NODES = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        accepted,
	input  wire logic                        first_packet,
	input  wire logic [ldm_pkg::RxBits-1:0]  rx_node,
	output logic                             q_valid,
	input  wire logic                        q_ready,
	output ldm_pkg::ldm_cmd_t                q_cmd
);
	ldm_pkg::ldm_cmd_t mem_q [2];
	logic [1:0] wp_q, rp_q;
	logic [1:0] fill;
	ldm_pkg::ldm_cmd_t cmd;

	assign fill = wp_q - rp_q;
	assign in_ready = (fill != 2'd2);
	assign q_valid = (fill != 2'd0);
	assign q_cmd = mem_q[rp_q[0]];

	always_comb begin
		cmd.rx_node = rx_node;
		cmd.in_range = ({28'd0, rx_node} < 32'(NODES));
		cmd.count = accepted & first_packet;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mem_q[wp_q[0]] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (in_valid && in_ready) begin
				wp_q <= wp_q + 2'd1;
			end
			if (q_valid && q_ready) begin
				rp_q <= rp_q + 2'd1;
			end
		end
	end
endmodule
`default_nettype wire

[rtl/ldm_back.sv]
// Back end: counter update, sum sweep and serial division of the index.
`default_nettype none
module ldm_back #(
	parameter int unsigned NODES = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	output logic                              q_ready,
	input  wire ldm_pkg::ldm_cmd_t            q_cmd,
	input  wire logic [31:0]                  max_index_q16,
	input  wire logic [ldm_pkg::MaskBits-1:0] target_mask,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [49:0]                       out_data
);
	localparam int unsigned NB = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int unsigned MN = (NODES < 16) ? NODES : 16;
	localparam int unsigned SB = COUNT_BITS + 8;
	localparam int unsigned QB = 2 * COUNT_BITS + 8;
	localparam int unsigned NUMB = QB + 8 + 16;
	localparam int unsigned DB = SB + 9;
	localparam int unsigned CB = $clog2(NUMB + 1);
	localparam logic [COUNT_BITS-1:0] CntMax = '1;

	ldm_pkg::ldm_state_t state_q, state_d;
	logic [COUNT_BITS-1:0] cnt_q [NODES];
	logic violated_q;
	logic [NB-1:0] rx_q;
	logic in_range_q, evaluated_q;
	logic [NB:0] sw_q;
	logic [8:0] n_q;
	logic [SB-1:0] s_q;
	logic [QB-1:0] sq_q;
	logic [COUNT_BITS-1:0] cur_s1;
	logic cur_v_s1;
	logic [2*COUNT_BITS-1:0] sqr_s1;
	logic mul_phase_q;
	logic [NUMB-1:0] num_q;
	logic [DB-1:0] den_q, rem_q;
	logic [CB-1:0] bit_q;
	logic [31:0] quo_q;
	logic sat_q;
	logic [31:0] idx_q;
	logic [15:0] rxcnt_q;
	logic [DB:0] rem_sh;
	logic [NB-1:0] rx_idx;
	logic is_target;
	logic [NB-1:0] sw_idx;
	logic sw_tgt;
	logic [COUNT_BITS-1:0] cnt_next;

	assign rx_idx = NB'(q_cmd.rx_node);
	assign sw_idx = sw_q[NB-1:0];
	assign sw_tgt = (32'(sw_idx) < 32'(MN)) ? target_mask[4'(sw_idx)] : 1'b0;
	assign is_target = (32'(rx_idx) < 32'(MN)) ? target_mask[4'(rx_idx)] : 1'b0;
	assign rem_sh = {rem_q, num_q[NUMB-1]};
	assign cnt_next = (q_cmd.count && cnt_q[rx_idx] != CntMax) ? cnt_q[rx_idx] + 1'b1
		: cnt_q[rx_idx];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ldm_pkg::ST_IDLE: begin
				if (q_valid) begin
					state_d = (q_cmd.in_range && q_cmd.count && is_target)
						? ldm_pkg::ST_SWEEP : ldm_pkg::ST_OUT;
				end
			end
			ldm_pkg::ST_SWEEP: begin
				if (sw_q == (NB+1)'(NODES + 1) && mul_phase_q) begin
					state_d = ldm_pkg::ST_DIV;
				end
			end
			ldm_pkg::ST_DIV: begin
				if (den_q == '0 || bit_q == '0) begin
					state_d = ldm_pkg::ST_OUT;
				end
			end
			ldm_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = ldm_pkg::ST_IDLE;
				end
			end
			default: state_d = ldm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready = (state_q == ldm_pkg::ST_IDLE);
		out_valid = (state_q == ldm_pkg::ST_OUT);
		out_data = {rxcnt_q, violated_q, idx_q, evaluated_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ldm_pkg::ST_IDLE;
			violated_q <= 1'b0;
			for (int i = 0; i < NODES; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ldm_pkg::ST_IDLE && q_valid && q_cmd.in_range && q_cmd.count
				&& cnt_q[rx_idx] != CntMax) begin
				cnt_q[rx_idx] <= cnt_q[rx_idx] + 1'b1;
			end
			if (state_q == ldm_pkg::ST_DIV && (den_q == '0 || bit_q == '0) && den_q != '0) begin
				if (sat_q || quo_q > max_index_q16
					|| (quo_q == max_index_q16 && rem_q != '0)) begin
					violated_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ldm_pkg::ST_IDLE: begin
				rx_q <= rx_idx;
				in_range_q <= q_cmd.in_range;
				evaluated_q <= q_cmd.in_range & q_cmd.count & is_target;
				sw_q <= '0;
				n_q <= '0;
				s_q <= '0;
				sq_q <= '0;
				mul_phase_q <= 1'b0;
				cur_v_s1 <= 1'b0;
				idx_q <= '0;
			end
			ldm_pkg::ST_SWEEP: begin
				if (!mul_phase_q) begin
					if (sw_q != (NB+1)'(NODES) && sw_q != (NB+1)'(NODES + 1)) begin
						cur_s1 <= cnt_q[sw_idx];
						cur_v_s1 <= sw_tgt;
					end else begin
						cur_v_s1 <= 1'b0;
					end
					mul_phase_q <= 1'b1;
				end else begin
					if (cur_v_s1) begin
						n_q <= n_q + 9'd1;
						s_q <= s_q + SB'(cur_s1);
						sqr_s1 <= cur_s1 * cur_s1;
					end else begin
						sqr_s1 <= '0;
					end
					if (sw_q != '0) begin
						sq_q <= sq_q + QB'(sqr_s1);
					end
					if (sw_q != (NB+1)'(NODES + 1)) begin
						sw_q <= sw_q + 1'b1;
						mul_phase_q <= 1'b0;
					end
					if (sw_q == (NB+1)'(NODES + 1)) begin
						num_q <= NUMB'({(QB+9)'(n_q) * (QB+9)'(sq_q + QB'(sqr_s1))
							- (QB+9)'(s_q) * (QB+9)'(s_q), 16'd0});
						den_q <= DB'(n_q) * DB'(s_q);
						rem_q <= '0;
						quo_q <= '0;
						sat_q <= 1'b0;
						bit_q <= CB'(NUMB);
					end
				end
			end
			ldm_pkg::ST_DIV: begin
				if (den_q != '0 && bit_q != '0) begin
					num_q <= num_q << 1;
					bit_q <= bit_q - 1'b1;
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= DB'(rem_sh - {1'b0, den_q});
						if (bit_q > CB'(32)) begin
							sat_q <= 1'b1;
						end else begin
							quo_q <= {quo_q[30:0], 1'b1};
						end
					end else begin
						rem_q <= rem_sh[DB-1:0];
						if (bit_q <= CB'(32)) begin
							quo_q <= {quo_q[30:0], 1'b0};
						end
					end
				end else begin
					idx_q <= (den_q == '0) ? 32'd0 : (sat_q ? 32'hFFFF_FFFF : quo_q);
				end
			end
			default: begin
			end
		endcase
		if (state_q == ldm_pkg::ST_IDLE) begin
			rxcnt_q <= q_cmd.in_range ? 16'(cnt_next) : 16'd0;
		end else if (state_q != ldm_pkg::ST_OUT) begin
			rxcnt_q <= in_range_q ? 16'(cnt_q[rx_q]) : 16'd0;
		end
	end
endmodule
`default_nettype wire

[rtl/load_dispersion_monitor.sv]
// Top level of the load dispersion monitor.
//  channel | direction | tdata / payload
//  s_axis  | in        | accepted, first_packet, rx_node
//  m_axis  | out       | evaluated, index_q16, violation, rx_count
//  cfg     | in        | cfg_index (0 threshold, 1 target mask), cfg_data
// A request is written into the two-entry queue before the back end takes it.
// An evaluated request then passes through the accept state, the sum sweep,
// the serial divider steps and a finishing step before its result is shown.
// Other requests show their result in the cycle after the back end takes them.
// Reset clears all counters and the violation flag; both sides may stall freely.
`default_nettype none
module load_dispersion_monitor #(
	parameter int unsigned NODES = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // accepted, first_packet, rx_node[3:0], zero pad
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [55:0]      m_axis_tdata,  // evaluated, index_q16, violation, rx_count, pad
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic q_valid, q_ready;
	ldm_pkg::ldm_cmd_t q_cmd;
	logic [31:0] max_index_q;
	logic [ldm_pkg::MaskBits-1:0] target_mask_q;
	logic [49:0] res;

	assign cfg_ready = 1'b1;
	assign m_axis_tdata = {6'd0, res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_index_q <= 32'd65536;
			target_mask_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ldm_pkg::CfgMaxIndex: max_index_q <= cfg_data;
				ldm_pkg::CfgTargetMask: target_mask_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	ldm_front #(.NODES(NODES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.accepted(s_axis_tdata[0]), .first_packet(s_axis_tdata[1]),
		.rx_node(s_axis_tdata[5:2]),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	ldm_back #(.NODES(NODES), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.max_index_q16(max_index_q), .target_mask(target_mask_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);
endmodule
`default_nettype wire

[dv/load_dispersion_monitor_tb.sv]
// Self-checking testbench for the load dispersion monitor: drives random and directed requests and compares each result.
`timescale 1ns / 100ps
module load_dispersion_monitor_tb;

	typedef struct packed {
		logic [15:0] rx_count;
		logic        violation;
		logic [31:0] index_q16;
		logic        evaluated;
	} ldm_result_t;

	class dispersion_scoreboard;
		logic [15:0] counts [16];
		bit          sticky;
		logic [31:0] limit_q16;
		logic [15:0] targets;
		ldm_result_t pending [$];
		int          errors;
		int          checked;
		int          evals;

		function void clear();
			foreach (counts[i]) counts[i] = '0;
			sticky = 0;
			limit_q16 = 32'd65536;
			targets = '0;
			errors = 0;
			checked = 0;
			evals = 0;
		endfunction

		function void note_request(bit acc, bit first, logic [3:0] rx);
			ldm_result_t r;
			longint unsigned n, s, d, q, rem, den;
			logic [127:0] num;
			bit sat, over;
			r = '0;
			if (acc && first) begin
				if (counts[rx] != 16'hFFFF)
					counts[rx] = counts[rx] + 16'd1;
				if (targets[rx]) begin
					n = 0; s = 0; num = '0;
					for (int i = 0; i < 16; i++) begin
						if (!targets[i])
							continue;
						n++;
						s += counts[i];
						for (int j = i + 1; j < 16; j++) begin
							if (!targets[j])
								continue;
							d = counts[i] > counts[j] ? counts[i] - counts[j] : counts[j] - counts[i];
							num += 128'(d * d);
						end
					end
					den = n * s;
					over = 0;
					q = 0;
					if (den != 0) begin
						num = num << 16;
						rem = 0;
						sat = 0;
						for (int b = 127; b >= 0; b--) begin
							rem = (rem << 1) | longint'(num[b]);
							if (rem >= den) begin
								rem -= den;
								if (b >= 32)
									sat = 1;
								else
									q[b] = 1'b1;
							end
						end
						if (sat) begin
							over = 1;
							q = 64'hFFFFFFFF;
						end else
							over = (q > limit_q16) || (q == limit_q16 && rem != 0);
					end
					r.evaluated = 1;
					r.index_q16 = q[31:0];
					evals++;
					if (over)
						sticky = 1;
				end
			end
			r.violation = sticky;
			r.rx_count = counts[rx];
			pending.push_back(r);
		endfunction

		function void check_result(ldm_result_t got);
			ldm_result_t e;
			checked++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.evaluated !== e.evaluated) begin
				$display("%0t: evaluated exp %0d got %0d", $time, e.evaluated, got.evaluated);
				errors++;
			end
			if (got.index_q16 !== e.index_q16) begin
				$display("%0t: index_q16 exp %h got %h", $time, e.index_q16, got.index_q16);
				errors++;
			end
			if (got.violation !== e.violation) begin
				$display("%0t: violation exp %0d got %0d", $time, e.violation, got.violation);
				errors++;
			end
			if (got.rx_count !== e.rx_count) begin
				$display("%0t: rx_count exp %0d got %0d", $time, e.rx_count, got.rx_count);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;
	int          cycle_count;
	bit          hold_ready;
	dispersion_scoreboard board;

	load_dispersion_monitor uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 600000) begin
			$display("Timeout after %0d cycles.", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_result(ldm_result_t'(m_axis_tdata[49:0]));

	always @(negedge clk) begin
		if (!arst_n || hold_ready)
			m_axis_tready <= hold_ready ? 1'b0 : 1'b1;
		else if ($urandom_range(0, 99) < 3)
			m_axis_tready <= 1'b0;
		else if ($urandom_range(0, 99) < 70)
			m_axis_tready <= 1'b1;
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_request(bit acc, bit first, logic [3:0] rx, bit gaps);
		int g;
		g = gaps ? pick_gap() : 0;
		@(negedge clk);
		if (g != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, rx, first, acc};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_request(acc, first, rx);
	endtask

	task automatic stop_requests();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain();
		stop_requests();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == ldm_pkg::CfgMaxIndex)
			board.limit_q16 = value;
		else
			board.targets = value[15:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int items, logic [15:0] mask, logic [31:0] thr);
		int p;
		logic [3:0] rx;
		drain();
		write_reg(ldm_pkg::CfgTargetMask, {16'h0, mask});
		write_reg(ldm_pkg::CfgMaxIndex, thr);
		for (int k = 0; k < items; k++) begin
			p = $urandom_range(0, 99);
			rx = 4'($urandom_range(0, 15));
			if (p < 75)
				send_request(1, 1, rx, 1);
			else
				send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rx, 1);
		end
	endtask

	initial begin
		board = new();
		board.clear();
		cycle_count = 0;
		hold_ready = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		cfg_valid = 0;
		cfg_index = ldm_pkg::CfgMaxIndex;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: no targets, ignored events, then an evaluated set.
		send_request(0, 0, 4'd0, 0);
		send_request(1, 0, 4'd15, 0);
		send_request(0, 1, 4'd15, 0);
		send_request(1, 1, 4'd15, 0);
		drain();
		write_reg(ldm_pkg::CfgTargetMask, 32'h0000_8001);
		write_reg(ldm_pkg::CfgMaxIndex, 32'h0000_0000);
		send_request(1, 1, 4'd0, 0);
		send_request(1, 1, 4'd0, 0);
		send_request(1, 1, 4'd15, 0);
		send_request(1, 1, 4'd7, 0);
		drain();
		write_reg(ldm_pkg::CfgTargetMask, 32'hFFFF_FFFF);
		write_reg(ldm_pkg::CfgMaxIndex, 32'hFFFF_FFFF);
		for (int i = 0; i < 16; i++)
			send_request(1, 1, i[3:0], 0);
		drain();

		// Hold the output back while requests pile up.
		hold_ready = 1;
		for (int i = 0; i < 3; i++)
			send_request(1, 1, 4'd3, 0);
		stop_requests();
		repeat (300) @(posedge clk);
		hold_ready = 0;

		random_phase(220, 16'h00F0, 32'h0000_8000);
		random_phase(200, 16'hFFFF, 32'h0002_0000);
		random_phase(150, 16'h0003, 32'h0000_0000);
		random_phase(180, 16'($urandom_range(1, 16'hFFFF)), $urandom());
		random_phase(170, 16'h8421, 32'hFFFF_FFFF);
		drain();

		$display("Checked %0d results, %0d with the dispersion index evaluated,",
			board.checked, board.evals);
		$display("over several target sets and thresholds including the extremes.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
